### rtl/tmrq_pkg.sv
// ----------------------------------------------------------------------------
// tmrq_pkg
// Register codes and fixed widths shared by the triangle quality block.
// ----------------------------------------------------------------------------
package tmrq_pkg;

	localparam int DIM_W = 2;

	typedef logic [DIM_W-1:0] dim_t;

	localparam dim_t DIM_PLANAR  = 2'd2;
	localparam dim_t DIM_SPATIAL = 2'd3;

endpackage

### rtl/tmrq_if.sv
// ----------------------------------------------------------------------------
// tmrq_tri_if / tmrq_res_if
// Valid/ready channels for one triangle word and one quality word.
// ----------------------------------------------------------------------------
interface tmrq_tri_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] vertex0_x;
	logic signed [CW-1:0] vertex0_y;
	logic signed [CW-1:0] vertex0_z;
	logic signed [CW-1:0] vertex1_x;
	logic signed [CW-1:0] vertex1_y;
	logic signed [CW-1:0] vertex1_z;
	logic signed [CW-1:0] vertex2_x;
	logic signed [CW-1:0] vertex2_y;
	logic signed [CW-1:0] vertex2_z;

	modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
		vertex1_z, vertex2_x, vertex2_y, vertex2_z, input ready);
	modport sink (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
		vertex1_z, vertex2_x, vertex2_y, vertex2_z, output ready);
endinterface

interface tmrq_res_if #(parameter int QW = 17);
	logic          valid;
	logic          ready;
	logic [QW-1:0] quality;
	logic          degenerate;

	modport source (output valid, quality, degenerate, input ready);
	modport sink (input valid, quality, degenerate, output ready);
endinterface

### rtl/triangle_mean_ratio_quality.sv
// ----------------------------------------------------------------------------
// triangle_mean_ratio_quality
// Mean-ratio quality of one triangle per cycle while the output flows, exact integer pipeline.
// ----------------------------------------------------------------------------
// Usage:
// tri_in carries one triangle word (three vertices, signed coordinates);
// res_out carries quality (unsigned, 2^QUALITY_FRAC_BITS = 1.0) and the
// degenerate flag, set with quality 0 when all three vertices coincide.
// cfg_wen/cfg_wdata write the dimension register (2 planar, otherwise 3-D);
// write it only while the pipeline is empty.
// One triangle is accepted every cycle while the output flows. The pipeline
// includes the bit-per-stage square root
// (2*COORD_WIDTH+QUALITY_FRAC_BITS+6 stages)
// and the bit-per-stage divider (QUALITY_FRAC_BITS+1 stages).
// When res_out stalls with a word held, the whole pipeline holds and
// tri_in.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the dimension register to 3.
// ----------------------------------------------------------------------------
module triangle_mean_ratio_quality
	import tmrq_pkg::*;
#(
	parameter int COORD_WIDTH       = 16,
	parameter int QUALITY_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [DIM_W-1:0]  cfg_wdata,
	tmrq_tri_if.sink          tri_in,
	tmrq_res_if.source        res_out
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = QUALITY_FRAC_BITS;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = 2 * DW + 4;
	localparam int XPW = 2 * DW + 1;
	localparam int XSW = 2 * XPW;
	localparam int C2W = 4 * DW + 4;
	localparam int YW  = C2W + 4;
	localparam int RW  = YW / 2 + F;
	localparam int QW  = F + 1;

	dim_t dim_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_SPATIAL;
		end else if (cfg_wen) begin
			dim_q <= cfg_wdata;
		end
	end

	assign adv          = !res_out.valid || res_out.ready;
	assign tri_in.ready = adv;

	// stage 1: edge vectors
	logic                 v_s1;
	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [DW-1:0] c_s1 [3];
	logic                 planar;

	assign planar = (dim_q == DIM_PLANAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tri_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1[0] <= DW'(tri_in.vertex1_x) - DW'(tri_in.vertex0_x);
			a_s1[1] <= DW'(tri_in.vertex1_y) - DW'(tri_in.vertex0_y);
			b_s1[0] <= DW'(tri_in.vertex2_x) - DW'(tri_in.vertex1_x);
			b_s1[1] <= DW'(tri_in.vertex2_y) - DW'(tri_in.vertex1_y);
			c_s1[0] <= DW'(tri_in.vertex0_x) - DW'(tri_in.vertex2_x);
			c_s1[1] <= DW'(tri_in.vertex0_y) - DW'(tri_in.vertex2_y);
			if (planar) begin
				a_s1[2] <= '0;
				b_s1[2] <= '0;
				c_s1[2] <= '0;
			end else begin
				a_s1[2] <= DW'(tri_in.vertex1_z) - DW'(tri_in.vertex0_z);
				b_s1[2] <= DW'(tri_in.vertex2_z) - DW'(tri_in.vertex1_z);
				c_s1[2] <= DW'(tri_in.vertex0_z) - DW'(tri_in.vertex2_z);
			end
		end
	end

	// stage 2: squares and cross products
	logic                 v_s2;
	logic signed [PW-1:0] sq_s2 [9];
	logic signed [PW-1:0] pr_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k]     <= a_s1[k] * a_s1[k];
				sq_s2[k + 3] <= b_s1[k] * b_s1[k];
				sq_s2[k + 6] <= c_s1[k] * c_s1[k];
			end
			pr_s2[0] <= a_s1[1] * b_s1[2];
			pr_s2[1] <= a_s1[2] * b_s1[1];
			pr_s2[2] <= a_s1[2] * b_s1[0];
			pr_s2[3] <= a_s1[0] * b_s1[2];
			pr_s2[4] <= a_s1[0] * b_s1[1];
			pr_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	// stage 3: edge sum and cross components
	logic                  v_s3;
	logic [SW-1:0]         s_s3;
	logic signed [XPW-1:0] x_s3 [3];
	logic [SW-1:0]         s_sum;

	always_comb begin
		s_sum = '0;
		for (int k = 0; k < 9; k++) begin
			s_sum = s_sum + {{(SW-PW){1'b0}}, sq_s2[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3 <= s_sum;
			for (int k = 0; k < 3; k++) begin
				x_s3[k] <= {pr_s2[2*k][PW-1], pr_s2[2*k]}
					- {pr_s2[2*k+1][PW-1], pr_s2[2*k+1]};
			end
		end
	end

	// stage 4: squared cross components
	logic                  v_s4;
	logic [SW-1:0]         s_s4;
	logic signed [XSW-1:0] xs_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s4 <= s_s3;
			for (int k = 0; k < 3; k++) begin
				xs_s4[k] <= x_s3[k] * x_s3[k];
			end
		end
	end

	// stage 5: squared area term
	logic           v_s5;
	logic [SW-1:0]  s_s5;
	logic [C2W-1:0] c2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s5  <= s_s4;
			c2_s5 <= {{(C2W-XSW){1'b0}}, xs_s4[0]} + {{(C2W-XSW){1'b0}}, xs_s4[1]}
				+ {{(C2W-XSW){1'b0}}, xs_s4[2]};
		end
	end

	// stage 6: radicand 12*c2, root state cleared
	logic          sq_v    [RW+1];
	logic [SW-1:0] sq_s    [RW+1];
	logic [YW-1:0] sq_x    [RW+1];
	logic [RW+1:0] sq_rem  [RW+1];
	logic [RW-1:0] sq_root [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			sq_v[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0]    <= s_s5;
			sq_x[0]    <= {c2_s5, 3'b000} + {1'b0, c2_s5, 2'b00};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
		end
	end

	// square root of 12*c2*2^(2F), one root bit per stage
	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		logic [RW+2:0] rem_sh;
		logic [RW+2:0] trial;
		logic [RW+2:0] diff;
		logic          take;

		assign rem_sh = {sq_rem[i][RW:0], sq_x[i][YW-1:YW-2]};
		assign trial  = {1'b0, sq_root[i], 2'b01};
		assign diff   = rem_sh - trial;
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else if (adv) begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[i+1]    <= sq_s[i];
				sq_x[i+1]    <= {sq_x[i][YW-3:0], 2'b00};
				sq_rem[i+1]  <= take ? diff[RW+1:0] : rem_sh[RW+1:0];
				sq_root[i+1] <= {sq_root[i][RW-2:0], take};
			end
		end
	end

	// divide root by edge sum, one quotient bit per stage
	logic          dv_v   [QW+1];
	logic [SW-1:0] dv_s   [QW+1];
	logic [RW-1:0] dv_r   [QW+1];
	logic [SW-1:0] dv_rem [QW+1];
	logic [QW-1:0] dv_q   [QW+1];

	always_comb begin
		dv_v[0]   = sq_v[RW];
		dv_s[0]   = sq_s[RW];
		dv_r[0]   = sq_root[RW];
		dv_rem[0] = {{(SW-(RW-QW)){1'b0}}, sq_root[RW][RW-1:QW]};
		dv_q[0]   = '0;
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [SW:0] rem_sh;
		logic [SW:0] diff;
		logic        take;

		assign rem_sh = {dv_rem[j], dv_r[j][F-j]};
		assign diff   = rem_sh - {1'b0, dv_s[j]};
		assign take   = (rem_sh >= {1'b0, dv_s[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+1]   <= dv_s[j];
				dv_r[j+1]   <= dv_r[j];
				dv_rem[j+1] <= take ? diff[SW-1:0] : rem_sh[SW-1:0];
				dv_q[j+1]   <= (QW > 1) ? {dv_q[j][QW-2:0], take} : QW'(take);
			end
		end
	end

	// output register
	logic          out_v_q;
	logic [QW-1:0] quality_q;
	logic          degenerate_q;
	logic          deg;
	logic          over;

	assign deg  = (dv_s[QW] == '0);
	assign over = dv_q[QW][QW-1] && (dv_q[QW][QW-2:0] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degenerate_q <= deg;
			if (deg) begin
				quality_q <= '0;
			end else if (over) begin
				quality_q <= {1'b1, {(QW-1){1'b0}}};
			end else begin
				quality_q <= dv_q[QW];
			end
		end
	end

	assign res_out.valid      = out_v_q;
	assign res_out.quality    = quality_q;
	assign res_out.degenerate = degenerate_q;

`ifndef SYNTHESIS
	a_qual_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (quality_q <= {1'b1, {(QW-1){1'b0}}}))
		else $error("quality above one");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && degenerate_q) |-> (quality_q == '0))
		else $error("degenerate word with nonzero quality");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(sq_root[RW]) && $stable(dv_q[QW]) && $stable(sq_v[0])))
		else $error("pipeline moved during stall");
`endif

endmodule
